// ----- hdl/trial_division_prime_test_top_assert.svh -----
// Assertion macros for the trial division RTL.
// Each check is clocked on the rising edge and is held off while reset is low.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every edge.
`define TDP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define TDP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define TDP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ----- hdl/tdp_pkg.sv -----
`default_nettype none

package tdp_pkg;

    // First trial divisor of every test.
    localparam int FIRST_DIVISOR = 2;

    // Sequencer to divider: start one division.
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    // Divider to sequencer: status.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- hdl/tdp_if.sv -----
`default_nettype none

// Candidate channel.
interface tdp_cand_if #(
    parameter int VALUE_WIDTH = 31
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

// Result channel.
interface tdp_flag_if;
    logic valid;
    logic ready;
    logic prime_flag;

    modport source (output valid, output prime_flag, input ready);
    modport sink   (input valid, input prime_flag, output ready);
endinterface

`default_nettype wire

// ----- hdl/tdp_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tdp_div
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH   = 31,
    parameter int DIVISOR_WIDTH = 17
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire  t_div_ctrl          i_ctrl,
    input  wire  [VALUE_WIDTH-1:0]   i_dividend,
    input  wire  [DIVISOR_WIDTH-1:0] i_divisor,
    output t_div_stat                o_stat,
    output logic [VALUE_WIDTH-1:0]   o_quotient,
    output logic [DIVISOR_WIDTH-1:0] o_remainder
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0]   r_quo, n_quo;
    logic [DIVISOR_WIDTH-1:0] r_rem, n_rem;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic                     r_done, n_done;

    logic [DIVISOR_WIDTH:0]   shifted;
    logic [DIVISOR_WIDTH:0]   diff;
    logic                     fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign shifted = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign fits    = (shifted >= {1'b0, i_divisor});
    assign diff    = shifted - {1'b0, i_divisor};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_ctrl.start) begin
            n_quo = i_dividend;
            n_rem = '0;
            n_cnt = CW'(VALUE_WIDTH);
        end else if (r_cnt != '0) begin
            n_quo  = {r_quo[VALUE_WIDTH-2:0], fits};
            n_rem  = fits ? diff[DIVISOR_WIDTH-1:0] : shifted[DIVISOR_WIDTH-1:0];
            n_cnt  = r_cnt - CW'(1);
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    assign o_stat.busy  = (r_cnt != '0);
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

endmodule

`default_nettype wire

// ----- hdl/trial_division_prime_test_top.sv -----
// Each trial divisor takes one full pass of the bit-serial divider.
// Worst case near sqrt(2**VALUE_WIDTH) trial divisors for one candidate.
// Throughput: one candidate at a time; the next is taken once the test completes.
// A finished flag sits in the output register while the next candidate is taken.
// Reset: synchronous, active low; clears sequencer, divider count and done, and output valid.
`default_nettype none

`include "trial_division_prime_test_top_assert.svh"

module trial_division_prime_test_top
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 31
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    tdp_cand_if.sink  i_cand,
    tdp_flag_if.source o_result
);

    // Divisor must reach one past sqrt(2**VALUE_WIDTH).
    localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_cand, n_cand;
    logic [DW-1:0]          r_divisor, n_divisor;
    logic                   r_start, n_start;
    logic                   r_out_valid, n_out_valid;
    logic                   r_flag, n_flag;

    t_div_ctrl              div_ctrl;
    t_div_stat              div_stat;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DW-1:0]          remainder;

    logic                   in_take;
    logic                   out_free;
    logic                   small_cand;
    logic                   past_root;
    logic                   divides;

    assign in_take  = i_cand.valid && i_cand.ready;
    // Output register can take a new flag when empty or being drained now.
    assign out_free = !r_out_valid || o_result.ready;

    // Zero and one are not prime; the loop would call them prime.
    assign small_cand = (r_cand < VALUE_WIDTH'(2));
    // Loop runs while divisor <= candidate / divisor: stop once quotient < divisor.
    assign past_root  = (quotient < VALUE_WIDTH'(r_divisor));
    assign divides    = (remainder == '0);

    assign div_ctrl.start = r_start;

    tdp_div #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .DIVISOR_WIDTH (DW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (div_ctrl),
        .i_dividend  (r_cand),
        .i_divisor   (r_divisor),
        .o_stat      (div_stat),
        .o_quotient  (quotient),
        .o_remainder (remainder)
    );

    always_comb begin
        n_state     = r_state;
        n_cand      = r_cand;
        n_divisor   = r_divisor;
        n_start     = 1'b0;
        n_flag      = r_flag;
        n_out_valid = r_out_valid && !o_result.ready;

        unique case (r_state)
            ST_IDLE: begin
                // Capture the candidate and launch the first trial division.
                if (in_take) begin
                    n_cand    = i_cand.candidate;
                    n_divisor = DW'(FIRST_DIVISOR);
                    n_start   = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                // Wait for the divider to finish this divisor.
                if (div_stat.done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (small_cand || past_root || divides) begin
                    // Verdict reached: hold here until the output register frees up.
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_flag      = !small_cand && past_root;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    // Advance to the next divisor.
                    n_divisor = r_divisor + DW'(1);
                    n_start   = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cand    <= n_cand;
        r_divisor <= n_divisor;
        r_flag    <= n_flag;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    assign i_cand.ready        = (r_state == ST_IDLE);
    assign o_result.valid      = r_out_valid;
    assign o_result.prime_flag = r_flag;

    `TDP_ASSERT(a_start_idle_div, i_clk, i_rst_n, !div_ctrl.start || !div_stat.busy, "divider restarted while busy")
    `TDP_ASSERT(a_done_in_div, i_clk, i_rst_n, !div_stat.done || (r_state == ST_DIV), "division finished outside the wait state")
    `TDP_ASSERT(a_rem_below_div, i_clk, i_rst_n, !div_stat.done || (remainder < r_divisor), "remainder not below divisor")
    `TDP_ASSERT_NEXT(a_take_starts, i_clk, i_rst_n, in_take, div_ctrl.start && (r_divisor == DW'(FIRST_DIVISOR)), "accepted transaction did not start a division")

endmodule

`default_nettype wire
